// ===== rtl/ffa_pkg.sv =====
// Shared constants, types and codes for the first-fit heap allocator.
package ffa_pkg;

  localparam int HEAP_BYTES      = 65536;
  localparam int HEADER_BYTES    = 32;
  localparam int MIN_SPLIT_BYTES = 16;

  localparam int GRANULES  = HEAP_BYTES / 8;
  localparam int HDR_SPAN  = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int HDR_GRAN  = HDR_SPAN / 8;
  localparam int GW        = $clog2(GRANULES);
  localparam int PW        = $clog2(HEAP_BYTES + 1);
  localparam int FW        = GW + 2;
  localparam int NEED_W    = 17;
  localparam int CMP_W     = ((PW > NEED_W) ? PW : NEED_W) + 2;
  localparam int OFF_W     = 16;
  localparam int LEN_W     = 16;
  localparam int ST_W      = 2;
  localparam int OP_W      = 4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFIT = 2'd2;
  localparam logic [ST_W-1:0] ST_BADOFF = 2'd3;

  localparam logic [OP_W-1:0] OP_NONE = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR  = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd2;
  localparam logic [OP_W-1:0] OP_ACHK = 4'd3;
  localparam logic [OP_W-1:0] OP_ASPL = 4'd4;
  localparam logic [OP_W-1:0] OP_FCHK = 4'd5;
  localparam logic [OP_W-1:0] OP_FNX  = 4'd6;
  localparam logic [OP_W-1:0] OP_FPRV = 4'd7;
  localparam logic [OP_W-1:0] OP_FPW  = 4'd8;
  localparam logic [OP_W-1:0] OP_FPM  = 4'd9;
  localparam logic [OP_W-1:0] OP_FPZ  = 4'd10;

  typedef struct packed {
    logic          start;
    logic          inuse;
    logic [PW-1:0] pay;
  } blk_t;

  localparam int MW = $bits(blk_t);

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            finish;
    logic [ST_W-1:0] fin_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic is_free_req;
    logic zero_req;
    logic free_ok;
    logic hit;
    logic split;
    logic fol_ok;
    logic start;
    logic g_zero;
    logic merge;
  } sts_t;

endpackage

// ===== rtl/ffa_if.sv =====
// Request and response channel interfaces.
interface ffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [ffa_pkg::LEN_W-1:0]   alloc_bytes;
  logic [ffa_pkg::OFF_W-1:0]   payload_offset;
  modport source (output valid, mode, alloc_bytes, payload_offset, input ready);
  modport sink (input valid, mode, alloc_bytes, payload_offset, output ready);
endinterface

interface ffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ffa_pkg::ST_W-1:0]    status;
  logic [ffa_pkg::OFF_W-1:0]   granted_offset;
  modport source (output valid, status, granted_offset, input ready);
  modport sink (input valid, status, granted_offset, output ready);
endinterface

// ===== rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ffa_ctrl.sv =====
// Allocator controller: sequences clearing, search, split and merge steps.
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t cmd,
  output logic          req_ready
);
  import ffa_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ACHK = 4'd2;
  localparam logic [3:0] S_ASPL = 4'd3;
  localparam logic [3:0] S_FCHK = 4'd4;
  localparam logic [3:0] S_FNX  = 4'd5;
  localparam logic [3:0] S_FPRV = 4'd6;
  localparam logic [3:0] S_FPW  = 4'd7;
  localparam logic [3:0] S_FPM  = 4'd8;
  localparam logic [3:0] S_FPZ  = 4'd9;

  logic [3:0] state, state_next;

  assign req_ready = (state == S_IDLE) && sts.out_free;

  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    cmd.finish     = 1'b0;
    cmd.fin_status = ST_OK;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid && sts.out_free) begin
          cmd.op = OP_LOAD;
          if (!sts.is_free_req) begin
            if (sts.zero_req) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_ZERO;
            end else begin
              state_next = S_ACHK;
            end
          end else if (!sts.free_ok) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_BADOFF;
          end else begin
            state_next = S_FCHK;
          end
        end
      end
      S_ACHK: begin
        cmd.op = OP_ACHK;
        if (sts.hit) begin
          if (sts.split) begin
            state_next = S_ASPL;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else if (!sts.fol_ok) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOFIT;
          state_next     = S_IDLE;
        end
      end
      S_ASPL: begin
        cmd.op     = OP_ASPL;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_FCHK: begin
        cmd.op = OP_FCHK;
        if (!sts.start) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_BADOFF;
          state_next     = S_IDLE;
        end else if (sts.fol_ok) begin
          state_next = S_FNX;
        end else begin
          state_next = S_FPRV;
        end
      end
      S_FNX: begin
        cmd.op     = OP_FNX;
        state_next = S_FPRV;
      end
      S_FPRV: begin
        cmd.op = OP_FPRV;
        if (sts.g_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FPW;
        end
      end
      S_FPW: begin
        cmd.op     = OP_FPW;
        state_next = S_FPM;
      end
      S_FPM: begin
        cmd.op = OP_FPM;
        if (sts.merge) begin
          state_next = S_FPZ;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FPZ: begin
        cmd.op     = OP_FPZ;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/ffa_dp.sv =====
// Allocator datapath: block tables, chain arithmetic and result register.
module ffa_dp (
  input  logic          clk,
  input  logic          rst,
  input  ffa_pkg::cmd_t cmd,
  output ffa_pkg::sts_t sts,
  ffa_req_if.sink       req,
  ffa_rsp_if.source     rsp
);
  import ffa_pkg::*;

  blk_t              rd;
  logic              m_we;
  logic [GW-1:0]     m_wa, m_ra;
  blk_t              m_wd;
  logic              p_we;
  logic [GW-1:0]     p_wa, p_wd, p_ra, p_rd;

  logic [GW-1:0]     clr_cnt, g, ng, nxr, pg;
  logic [NEED_W-1:0] need;
  logic [PW-1:0]     curpay;
  logic              is_alloc;

  logic [NEED_W-1:0] need_in;
  logic [OFF_W-1:0]  b;
  logic [FW-1:0]     bgw, fol, ng_c, nn, after;
  logic [PW-1:0]     rem, sum;
  logic [GW-1:0]     base;
  logic              fits, split_sz;
  logic [FW+2:0]     goff;

  ffa_ram #(.WIDTH(MW), .DEPTH(GRANULES)) u_blk (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(rd)
  );

  ffa_ram #(.WIDTH(GW), .DEPTH(GRANULES)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
  );

  assign need_in = (NEED_W'(req.alloc_bytes) + NEED_W'(7)) & ~NEED_W'(7);
  assign b       = req.payload_offset - OFF_W'(HDR_SPAN);
  assign bgw     = FW'(b >> 3);
  assign fol     = FW'(g) + FW'(HDR_GRAN) + FW'(rd.pay >> 3);
  assign ng_c    = FW'(g) + FW'(HDR_GRAN) + FW'(need >> 3);
  assign rem     = rd.pay - PW'(need) - PW'(HDR_SPAN);
  assign nn      = FW'(ng) + FW'(HDR_GRAN) + FW'(curpay >> 3);
  assign sum     = rd.pay + PW'(HDR_SPAN) + curpay;
  assign base    = (cmd.op == OP_FNX) ? g : pg;
  assign after   = FW'(base) + FW'(HDR_GRAN) + FW'(sum >> 3);
  assign fits    = CMP_W'(rd.pay) >= CMP_W'(need);
  assign split_sz = CMP_W'(rd.pay) >=
                    CMP_W'(need) + CMP_W'(HDR_SPAN) + CMP_W'(MIN_SPLIT_BYTES);
  assign goff    = (FW+3)'({g, 3'b000}) + (FW+3)'(HDR_SPAN);

  assign sts.clr_last    = clr_cnt == GW'(GRANULES - 1);
  assign sts.out_free    = !rsp.valid || rsp.ready;
  assign sts.is_free_req = req.mode;
  assign sts.zero_req    = req.alloc_bytes == '0;
  assign sts.free_ok     = (req.payload_offset >= OFF_W'(HDR_SPAN)) && (b[2:0] == 3'b000)
                           && (bgw < FW'(GRANULES));
  assign sts.hit         = !rd.inuse && fits;
  assign sts.split       = split_sz && (ng_c < FW'(GRANULES));
  assign sts.fol_ok      = fol < FW'(GRANULES);
  assign sts.start       = rd.start;
  assign sts.g_zero      = g == '0;
  assign sts.merge       = !rd.inuse;

  assign req.ready = 1'b0 | (cmd.op == OP_LOAD);

  always_comb begin
    m_we = 1'b0;
    m_wa = g;
    m_wd = '0;
    m_ra = g;
    p_we = 1'b0;
    p_wa = ng;
    p_wd = g;
    p_ra = g;
    case (cmd.op)
      OP_CLR: begin
        m_we = 1'b1;
        m_wa = clr_cnt;
        if (clr_cnt == '0) begin
          m_wd = '{start: 1'b1, inuse: 1'b0, pay: PW'(GRANULES * 8 - HDR_SPAN)};
        end
      end
      OP_LOAD: begin
        m_ra = req.mode ? bgw[GW-1:0] : '0;
      end
      OP_ACHK: begin
        m_ra = fol[GW-1:0];
        if (sts.hit) begin
          m_we = 1'b1;
          m_wd = '{start: 1'b1, inuse: 1'b1, pay: sts.split ? PW'(need) : rd.pay};
          p_we = sts.split;
          p_wa = ng_c[GW-1:0];
          p_wd = g;
        end
      end
      OP_ASPL: begin
        m_we = 1'b1;
        m_wa = ng;
        m_wd = '{start: 1'b1, inuse: 1'b0, pay: curpay};
        p_we = nn < FW'(GRANULES);
        p_wa = nn[GW-1:0];
        p_wd = ng;
      end
      OP_FCHK: begin
        m_ra = fol[GW-1:0];
      end
      OP_FNX: begin
        if (!rd.inuse) begin
          m_we = 1'b1;
          m_wa = nxr;
          p_we = after < FW'(GRANULES);
          p_wa = after[GW-1:0];
          p_wd = g;
        end
      end
      OP_FPRV: begin
        m_we = 1'b1;
        m_wd = '{start: 1'b1, inuse: 1'b0, pay: curpay};
        p_ra = g;
      end
      OP_FPW: begin
        m_ra = p_rd;
      end
      OP_FPM: begin
        if (!rd.inuse) begin
          m_we = 1'b1;
          m_wa = pg;
          m_wd = '{start: rd.start, inuse: 1'b0, pay: sum};
          p_we = after < FW'(GRANULES);
          p_wa = after[GW-1:0];
          p_wd = pg;
        end
      end
      OP_FPZ: begin
        m_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_alloc <= !req.mode;
        need     <= need_in;
        g        <= req.mode ? bgw[GW-1:0] : '0;
      end
      OP_ACHK: begin
        curpay <= rem;
        ng     <= ng_c[GW-1:0];
        if (!sts.hit) g <= fol[GW-1:0];
      end
      OP_FCHK: begin
        curpay <= rd.pay;
        nxr    <= fol[GW-1:0];
      end
      OP_FNX: begin
        if (!rd.inuse) curpay <= sum;
      end
      OP_FPW: begin
        pg <= p_rd;
      end
      default: ;
    endcase
    if (cmd.finish) begin
      rsp.status         <= cmd.fin_status;
      rsp.granted_offset <= (is_alloc && cmd.fin_status == ST_OK && cmd.op != OP_LOAD)
                            ? goff[OFF_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLR) clr_cnt <= clr_cnt + GW'(1);
      if (cmd.finish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator with split and coalesce.
//
//   channel  dir  fields                               width
//   req      in   mode, alloc_bytes, payload_offset     1/16/16
//   rsp      out  status, granted_offset               2/16
//
// Allocate: accept, then an ACHK step per block header walked, plus an
// ASPL step when the block is split; a zero size ends at accept. Free:
// ends at accept if the offset is rejected at once, in FCHK if it is not
// a block start, else runs FCHK, FNX, FPRV, FPW, FPM, FPZ as needed. The
// result register loads in the last step. The block table RAM's single
// read port sets the pace. After rst all GRANULES (8192) entries are
// swept before the first item is taken. One item is worked at a time;
// the next is taken only once rsp is empty or its item is being read out.
module first_fit_heap_allocator_unit (
  input logic       clk,
  input logic       rst,
  ffa_req_if.sink   req,
  ffa_rsp_if.source rsp
);
  import ffa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready_c;

  ffa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .sts(sts), .cmd(cmd),
    .req_ready(req_ready_c)
  );

  ffa_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .req(req), .rsp(rsp)
  );

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CLR) |-> !req.ready) else $error("item taken during clear");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable(rsp.status) && $stable(rsp.granted_offset)))
    else $error("waiting item dropped or changed");

  a_offset_only_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.granted_offset != '0) |-> (rsp.status == ST_OK))
    else $error("offset with error status");

  a_ready_match: assert property (@(posedge clk) disable iff (rst)
    req.ready == (req.valid && req_ready_c)) else $error("ready mismatch");
endmodule

// ===== tb/ffa_checker.sv =====
// Checker: watches both channels, predicts allocator results and compares them.
module ffa_checker (
  input  logic      clk,
  input  logic      rst,
  ffa_req_if        req,
  ffa_rsp_if        rsp,
  output int        errors,
  output int        pending
);
  import ffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] granted_offset;
  } grant_t;

  bit          is_start [GRANULES];
  bit          in_use   [GRANULES];
  int unsigned pay_bytes[GRANULES];
  int unsigned prev_blk [GRANULES];
  grant_t      expected_grants[$];

  function automatic int unsigned next_blk(int unsigned g);
    return g + HDR_GRAN + (pay_bytes[g] >> 3);
  endfunction

  function automatic grant_t heap_alloc(int unsigned bytes);
    grant_t      r;
    int unsigned need, g, steps, have, ng, nn;
    r = '0;
    g = 0;
    steps = 0;
    if (bytes == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    need = (bytes + 7) & ~32'd7;
    while (g < GRANULES && steps < GRANULES) begin
      have = pay_bytes[g];
      if (!in_use[g] && have >= need) begin
        if (have >= need + HDR_SPAN + MIN_SPLIT_BYTES) begin
          ng = g + HDR_GRAN + (need >> 3);
          if (ng < GRANULES) begin
            is_start[ng] = 1;
            in_use[ng] = 0;
            pay_bytes[ng] = have - need - HDR_SPAN;
            prev_blk[ng] = g;
            nn = next_blk(ng);
            if (nn < GRANULES) prev_blk[nn] = ng;
            pay_bytes[g] = need;
          end
        end
        in_use[g] = 1;
        r.granted_offset = OFF_W'(g * 8 + HDR_SPAN);
        return r;
      end
      g = next_blk(g);
      steps++;
    end
    r.status = ST_NOFIT;
    return r;
  endfunction

  function automatic grant_t heap_free(int unsigned off);
    grant_t      r;
    int unsigned b, g, nx, pg, aft;
    r = '0;
    if (off < HDR_SPAN) begin
      r.status = ST_BADOFF;
      return r;
    end
    b = off - HDR_SPAN;
    if ((b & 7) != 0 || (b >> 3) >= GRANULES || !is_start[b >> 3]) begin
      r.status = ST_BADOFF;
      return r;
    end
    g = b >> 3;
    in_use[g] = 0;
    nx = next_blk(g);
    if (nx < GRANULES && !in_use[nx]) begin
      pay_bytes[g] += HDR_SPAN + pay_bytes[nx];
      is_start[nx] = 0;
      pay_bytes[nx] = 0;
      aft = next_blk(g);
      if (aft < GRANULES) prev_blk[aft] = g;
    end
    if (g != 0) begin
      pg = prev_blk[g] % GRANULES;
      if (!in_use[pg]) begin
        pay_bytes[pg] += HDR_SPAN + pay_bytes[g];
        is_start[g] = 0;
        pay_bytes[g] = 0;
        aft = next_blk(pg);
        if (aft < GRANULES) prev_blk[aft] = pg;
      end
    end
    return r;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < GRANULES; i++) begin
      is_start[i] = 0; in_use[i] = 0; pay_bytes[i] = 0; prev_blk[i] = 0;
    end
    is_start[0] = 1;
    pay_bytes[0] = GRANULES * 8 - HDR_SPAN;
  end

  assign pending = expected_grants.size();

  always @(posedge clk) begin
    grant_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        if (req.mode) expected_grants.push_back(heap_free(req.payload_offset));
        else          expected_grants.push_back(heap_alloc(req.alloc_bytes));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          want = expected_grants.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.granted_offset !== want.granted_offset)
            report("granted_offset", rsp.granted_offset, want.granted_offset);
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// Testbench top: clock, reset, stimulus for the allocator and the verdict.
module tb;
  import ffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending;
  longint cycles = 0;
  bit   hold_rsp = 0;
  int   live[$];

  ffa_req_if req();
  ffa_rsp_if rsp();

  first_fit_heap_allocator_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  ffa_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .errors(errors),
                   .pending(pending));

  initial forever #1 clk = ~clk;

  initial begin
    req.valid = 0; req.mode = 0; req.alloc_bytes = 0; req.payload_offset = 0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 20000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offsets granted by the block, used to aim frees at live blocks.
  always @(posedge clk)
    if (rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.granted_offset != 0)
      live.push_back(rsp.granted_offset);

  initial begin
    int w;
    @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 0;
        @(posedge clk);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 9) < 3) w = 0;
        rsp.ready <= 0;
        repeat (w) @(posedge clk);
        rsp.ready <= 1;
        @(posedge clk);
        while (!rsp.valid) @(posedge clk);
      end
    end
  end

  task automatic send(bit m, logic [15:0] nbytes, logic [15:0] off, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 8) : 0;
    if (w > 0) begin
      req.valid <= 0;
      repeat (w) @(posedge clk);
    end
    req.valid <= 1;
    req.mode <= m;
    req.alloc_bytes <= nbytes;
    req.payload_offset <= off;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic send_random(bit gaps);
    int k, idx;
    k = $urandom_range(0, 99);
    if (k < 45) send(0, (k < 5) ? 16'($urandom) : 16'($urandom_range(1, 600)),
                     16'($urandom), gaps);
    else if (k < 85 && live.size() > 0) begin
      idx = $urandom_range(0, live.size() - 1);
      send(1, 16'($urandom), 16'(live[idx]), gaps);
      if ($urandom_range(0, 3) != 0) live.delete(idx);
    end else if (k < 92) send(1, 16'($urandom), 16'($urandom), gaps);
    else send(0, 0, 16'($urandom), gaps);
  endtask

  initial begin
    int hold;
    repeat (5) @(posedge clk);
    rst <= 0;
    send(0, 0, 16'hffff, 0);
    send(0, 16'hffff, 0, 0);
    send(0, 1, 0, 0);
    send(0, 8, 0, 0);
    send(0, 9, 0, 0);
    send(0, 40, 0, 1);
    send(0, 100, 0, 1);
    send(1, 0, 16'd64, 0);
    send(1, 0, 16'd64, 0);
    send(1, 0, 0, 0);
    send(1, 0, 16'd31, 0);
    send(1, 0, 16'd33, 0);
    send(1, 0, 16'd36, 0);
    send(1, 0, 16'hffff, 0);
    send(1, 0, 16'hfff8, 0);
    send(1, 0, 16'd32, 0);
    send(0, 16'd65496, 0, 0);
    send(1, 0, 16'd32, 0);
    send(0, 16'd65504, 0, 0);
    send(0, 16'd65500, 0, 0);
    send(1, 0, 16'd32, 0);
    send(1, 0, 16'd32, 0);
    for (int i = 0; i < 1950; i++) begin
      if (i == 600) begin
        req.valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (i == 900) begin
        hold_rsp = 1;
        fork
          begin
            hold = 0;
            while (hold < 400) begin @(posedge clk); hold++; end
            hold_rsp = 0;
          end
        join_none
      end
      send_random((i % 300) >= 100);
    end
    req.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ffa_pkg.sv
rtl/ffa_if.sv
rtl/ffa_ram.sv
rtl/ffa_ctrl.sv
rtl/ffa_dp.sv
rtl/first_fit_heap_allocator_unit.sv
tb/ffa_checker.sv
tb/tb.sv
